@@ rtl/core/sld_pkg.sv @@
// ----------------------------------------------------------------------------
// sld_pkg
// Shared constants, codes and command types for the slew-limited PID drive.
// ----------------------------------------------------------------------------
package sld_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DRIVE_W   = 16;
	localparam int HELD_W    = DRIVE_W + FRAC_BITS;
	localparam int ERR_W     = 17;
	localparam int PERR_W    = 18;
	localparam int INTEG_W   = 48;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 64;
	localparam int DIVS_W    = 16;

	localparam logic [DIVS_W-1:0] MS_PER_S = 16'd1000;

	// register indexes
	localparam logic [2:0] REG_TARGET = 3'd0;
	localparam logic [2:0] REG_PROP   = 3'd1;
	localparam logic [2:0] REG_INTEG  = 3'd2;
	localparam logic [2:0] REG_DERIV  = 3'd3;
	localparam logic [2:0] REG_INVERT = 3'd4;
	localparam logic [2:0] REG_SLEW   = 3'd5;
	localparam logic [2:0] REG_BIAS   = 3'd6;

	// request kinds
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_STOP   = 2'd2;

	typedef logic [4:0] dp_op_t;

	localparam dp_op_t OP_NONE   = 5'd0;
	localparam dp_op_t OP_START  = 5'd1;
	localparam dp_op_t OP_LOAD   = 5'd2;
	localparam dp_op_t OP_ERR    = 5'd3;
	localparam dp_op_t OP_MUL_P  = 5'd4;
	localparam dp_op_t OP_MUL_ED = 5'd5;
	localparam dp_op_t OP_MUL_I  = 5'd6;
	localparam dp_op_t OP_CAP_I  = 5'd7;
	localparam dp_op_t OP_MUL_D  = 5'd8;
	localparam dp_op_t OP_CAP_D  = 5'd9;
	localparam dp_op_t OP_MUL_L  = 5'd10;
	localparam dp_op_t OP_CAP_L  = 5'd11;
	localparam dp_op_t OP_ACC_P  = 5'd12;
	localparam dp_op_t OP_ACC_I  = 5'd13;
	localparam dp_op_t OP_ACC_D  = 5'd14;
	localparam dp_op_t OP_ACC_B  = 5'd15;
	localparam dp_op_t OP_ACC_H  = 5'd16;
	localparam dp_op_t OP_LIMIT  = 5'd17;
	localparam dp_op_t OP_CLAMP  = 5'd18;
	localparam dp_op_t OP_WRITE  = 5'd19;

	typedef struct packed {
		dp_op_t op;
		logic   div_start;
		logic   div_by_dt;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
	} dp_status_t;

endpackage

@@ rtl/core/sld_divider.sv @@
// ----------------------------------------------------------------------------
// sld_divider
// Truncating signed-by-unsigned divider: one quotient bit per cycle for a
// variable divisor, a four-step reciprocal multiply for division by 1000.
// ----------------------------------------------------------------------------
module sld_divider
	import sld_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     by_const,
	input  logic signed [PROD_W-1:0] dividend,
	input  logic        [DIVS_W-1:0] divisor,
	output logic                     busy,
	output logic                     done,
	output logic signed [PROD_W-1:0] quot
);

	localparam int CNT_W    = $clog2(PROD_W);
	localparam int ACC_W    = 128;
	localparam int RECIP_SH = 67;
	// ceil(2^67 / 125); x / 1000 is (x >> 3) / 125, exact for 60-bit (x >> 3)
	localparam logic [63:0] RECIP = 64'h1062_4DD2_F1A9_FBE8;

	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [PROD_W-1:0] q_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              fix_q;
	logic              done_q;
	logic              neg_q;
	logic              const_q;
	logic [ACC_W-1:0]  acc_q;

	logic [DIVS_W:0]   trial;
	logic              ge;
	logic [PROD_W-1:0] mag;
	logic [59:0]       y;
	logic [31:0]       pa;
	logic [31:0]       pb;
	logic [63:0]       pp;
	logic [ACC_W-1:0]  pp_sh;
	logic [PROD_W-1:0] qmag;
	logic [CNT_W-1:0]  last_cnt;

	always_comb begin
		trial = {rem_q, q_q[PROD_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		mag   = dividend[PROD_W-1] ? PROD_W'(-dividend) : dividend;
		// partial products of (magnitude >> 3) times the reciprocal
		y     = q_q[62:3];
		pa    = cnt_q[1] ? {4'b0, y[59:32]} : y[31:0];
		pb    = cnt_q[0] ? RECIP[63:32] : RECIP[31:0];
		pp    = 64'(pa) * 64'(pb);
		unique case (cnt_q[1:0])
			2'd0:    pp_sh = ACC_W'(pp);
			2'd3:    pp_sh = ACC_W'(pp) << 64;
			default: pp_sh = ACC_W'(pp) << 32;
		endcase
		qmag     = const_q ? PROD_W'(acc_q >> RECIP_SH) : q_q;
		last_cnt = const_q ? CNT_W'(3) : CNT_W'(PROD_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= dividend[PROD_W-1];
			const_q <= by_const;
			q_q     <= mag;
			rem_q   <= '0;
			dvs_q   <= divisor;
			acc_q   <= '0;
		end else if (busy_q) begin
			if (const_q) begin
				acc_q <= acc_q + pp_sh;
			end else begin
				rem_q <= ge ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
				q_q   <= {q_q[PROD_W-2:0], ge};
			end
		end else if (fix_q) begin
			// apply the sign of the dividend, rounding toward zero
			q_q <= neg_q ? PROD_W'(-qmag) : qmag;
		end
	end

	assign busy = busy_q | fix_q;
	assign done = done_q;
	assign quot = $signed(q_q);

endmodule

@@ rtl/core/sld_datapath.sv @@
// ----------------------------------------------------------------------------
// sld_datapath
// Configuration, loop state, shared multiplier, divider and accumulator.
// ----------------------------------------------------------------------------
module sld_datapath
	import sld_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [15:0]        measured,
	input  logic [15:0]        elapsed_ms,
	input  logic [15:0]        start_output,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	output logic [DRIVE_W-1:0] drive
);

	localparam int P_W    = 49;
	localparam int D_W    = 60;
	localparam int LIM_W  = 38;
	localparam int DE1K_W = 28;

	localparam logic signed [PROD_W-1:0] INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 64'sd1;
	localparam logic signed [PROD_W-1:0] INTEG_MIN = -(64'sd1 <<< (INTEG_W - 1));
	localparam logic signed [PROD_W-1:0] TOP =
		$signed(PROD_W'(((1 << DRIVE_W) - 1)) << FRAC_BITS);

	logic        [15:0] target_q;
	logic signed [31:0] prop_q;
	logic signed [31:0] integ_q;
	logic signed [31:0] deriv_q;
	logic signed [31:0] bias_q;
	logic               invert_q;
	logic        [30:0] slew_q;

	logic        [15:0]        meas_q;
	logic        [15:0]        dt_q;
	logic signed [INTEG_W-1:0] integral_q;
	logic signed [PERR_W-1:0]  prev_q;
	logic        [HELD_W-1:0]  held_q;
	logic signed [ERR_W-1:0]   e_q;
	logic signed [DE1K_W-1:0]  de1k_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [P_W-1:0]     p_q;
	logic signed [D_W-1:0]     d_q;
	logic        [LIM_W-1:0]   lim_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic        [DRIVE_W-1:0] drive_q;

	logic signed [ERR_W-1:0]   diff;
	logic signed [ERR_W-1:0]   e_now;
	logic signed [PERR_W-1:0]  de;
	logic signed [DE1K_W-1:0]  de1k;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	logic signed [PROD_W-1:0]  quot;
	logic signed [PROD_W-1:0]  isum;
	logic signed [PROD_W-1:0]  lim_s;
	logic signed [PROD_W-1:0]  held_s;
	logic signed [PROD_W-1:0]  o_sum;
	logic                      div_busy;
	logic                      div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			prop_q   <= 32'sd1 <<< FRAC_BITS;
			integ_q  <= '0;
			deriv_q  <= '0;
			invert_q <= 1'b0;
			slew_q   <= 31'(MS_PER_S) << FRAC_BITS;
			bias_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET: target_q <= cfg_data[15:0];
				REG_PROP:   prop_q   <= $signed(cfg_data);
				REG_INTEG:  integ_q  <= $signed(cfg_data);
				REG_DERIV:  deriv_q  <= $signed(cfg_data);
				REG_INVERT: invert_q <= cfg_data[0];
				REG_SLEW:   slew_q   <= cfg_data[30:0];
				REG_BIAS:   bias_q   <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		diff  = $signed({1'b0, target_q} - {1'b0, meas_q});
		e_now = invert_q ? -diff : diff;
		de    = PERR_W'(e_now) - prev_q;
		de1k  = DE1K_W'(de) * DE1K_W'(MS_PER_S);
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_P: begin
				mul_a = MUL_W'(prop_q);
				mul_b = MUL_W'(e_q);
			end
			OP_MUL_ED: begin
				mul_a = MUL_W'(e_q);
				mul_b = $signed(MUL_W'(dt_q));
			end
			OP_MUL_I: begin
				mul_a = MUL_W'(integ_q);
				mul_b = prod_q[MUL_W-1:0];
			end
			OP_MUL_D: begin
				mul_a = MUL_W'(deriv_q);
				mul_b = MUL_W'(de1k_q);
			end
			OP_MUL_L: begin
				mul_a = $signed(MUL_W'(slew_q));
				mul_b = $signed(MUL_W'(dt_q));
			end
			default: begin
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// divisions by 1000 take the reciprocal path, the one by elapsed_ms the serial one
	sld_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.by_const (!cmd.div_by_dt),
		.dividend (prod_q),
		.divisor  (dt_q),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (quot)
	);

	always_comb begin
		isum   = PROD_W'(integral_q) + quot;
		lim_s  = $signed(PROD_W'(lim_q));
		held_s = $signed(PROD_W'(held_q));
		o_sum  = acc_q + held_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_q     <= '0;
			held_q     <= '0;
		end else begin
			unique case (cmd.op)
				OP_START: begin
					integral_q <= '0;
					prev_q     <= '0;
					held_q     <= HELD_W'(start_output) << FRAC_BITS;
				end
				OP_CAP_I: begin
					if (isum > INTEG_MAX) integral_q <= INTEG_MAX[INTEG_W-1:0];
					else if (isum < INTEG_MIN) integral_q <= INTEG_MIN[INTEG_W-1:0];
					else integral_q <= isum[INTEG_W-1:0];
				end
				OP_WRITE: begin
					held_q <= acc_q[HELD_W-1:0];
					prev_q <= PERR_W'(e_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				meas_q <= measured;
				dt_q   <= elapsed_ms;
			end
			OP_ERR: begin
				e_q    <= e_now;
				de1k_q <= de1k;
			end
			OP_MUL_P, OP_MUL_I, OP_MUL_D, OP_MUL_L: prod_q <= mul_p[PROD_W-1:0];
			OP_MUL_ED: begin
				p_q    <= prod_q[P_W-1:0];
				prod_q <= mul_p[PROD_W-1:0];
			end
			OP_CAP_D: d_q   <= quot[D_W-1:0];
			OP_CAP_L: lim_q <= quot[LIM_W-1:0];
			OP_ACC_P: acc_q <= PROD_W'(p_q);
			OP_ACC_I: acc_q <= acc_q + PROD_W'(integral_q);
			OP_ACC_D: acc_q <= acc_q + PROD_W'(d_q);
			OP_ACC_B: acc_q <= acc_q + PROD_W'(bias_q);
			OP_ACC_H: acc_q <= acc_q - held_s;
			OP_LIMIT: begin
				if (acc_q > lim_s) acc_q <= lim_s;
				else if (acc_q < -lim_s) acc_q <= -lim_s;
			end
			OP_CLAMP: begin
				if (o_sum < 0) acc_q <= '0;
				else if (o_sum > TOP) acc_q <= TOP;
				else acc_q <= o_sum;
			end
			OP_WRITE: drive_q <= acc_q[FRAC_BITS+DRIVE_W-1:FRAC_BITS];
			default: begin
			end
		endcase
	end

	assign status.div_busy = div_busy;
	assign status.div_done = div_done;
	assign drive           = drive_q;

endmodule

@@ rtl/core/sld_ctrl.sv @@
// ----------------------------------------------------------------------------
// sld_ctrl
// Sequencer for the drive update: handshakes, run flag and datapath commands.
// ----------------------------------------------------------------------------
module sld_ctrl
	import sld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [15:0] elapsed_ms,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_ERR    = 5'd1;
	localparam logic [4:0] S_MUL_P  = 5'd2;
	localparam logic [4:0] S_MUL_ED = 5'd3;
	localparam logic [4:0] S_MUL_I  = 5'd4;
	localparam logic [4:0] S_DIV_I  = 5'd5;
	localparam logic [4:0] S_WT_I   = 5'd6;
	localparam logic [4:0] S_MUL_D  = 5'd7;
	localparam logic [4:0] S_DIV_D  = 5'd8;
	localparam logic [4:0] S_WT_D   = 5'd9;
	localparam logic [4:0] S_MUL_L  = 5'd10;
	localparam logic [4:0] S_DIV_L  = 5'd11;
	localparam logic [4:0] S_WT_L   = 5'd12;
	localparam logic [4:0] S_ACC_P  = 5'd13;
	localparam logic [4:0] S_ACC_I  = 5'd14;
	localparam logic [4:0] S_ACC_D  = 5'd15;
	localparam logic [4:0] S_ACC_B  = 5'd16;
	localparam logic [4:0] S_ACC_H  = 5'd17;
	localparam logic [4:0] S_LIMIT  = 5'd18;
	localparam logic [4:0] S_CLAMP  = 5'd19;
	localparam logic [4:0] S_WRITE  = 5'd20;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       running_q;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d       = state_q;
		cmd.op        = OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_by_dt = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_START) begin
						cmd.op = OP_START;
					end else if (action == ACT_SAMPLE && running_q && elapsed_ms != '0) begin
						cmd.op  = OP_LOAD;
						state_d = S_ERR;
					end
				end
			end
			S_ERR: begin
				cmd.op  = OP_ERR;
				state_d = S_MUL_P;
			end
			S_MUL_P: begin
				cmd.op  = OP_MUL_P;
				state_d = S_MUL_ED;
			end
			S_MUL_ED: begin
				cmd.op  = OP_MUL_ED;
				state_d = S_MUL_I;
			end
			S_MUL_I: begin
				cmd.op  = OP_MUL_I;
				state_d = S_DIV_I;
			end
			S_DIV_I: begin
				cmd.div_start = 1'b1;
				state_d       = S_WT_I;
			end
			S_WT_I: begin
				if (status.div_done) begin
					cmd.op  = OP_CAP_I;
					state_d = S_MUL_D;
				end
			end
			S_MUL_D: begin
				cmd.op  = OP_MUL_D;
				state_d = S_DIV_D;
			end
			S_DIV_D: begin
				cmd.div_start = 1'b1;
				cmd.div_by_dt = 1'b1;
				state_d       = S_WT_D;
			end
			S_WT_D: begin
				if (status.div_done) begin
					cmd.op  = OP_CAP_D;
					state_d = S_MUL_L;
				end
			end
			S_MUL_L: begin
				cmd.op  = OP_MUL_L;
				state_d = S_DIV_L;
			end
			S_DIV_L: begin
				cmd.div_start = 1'b1;
				state_d       = S_WT_L;
			end
			S_WT_L: begin
				if (status.div_done) begin
					cmd.op  = OP_CAP_L;
					state_d = S_ACC_P;
				end
			end
			S_ACC_P: begin
				cmd.op  = OP_ACC_P;
				state_d = S_ACC_I;
			end
			S_ACC_I: begin
				cmd.op  = OP_ACC_I;
				state_d = S_ACC_D;
			end
			S_ACC_D: begin
				cmd.op  = OP_ACC_D;
				state_d = S_ACC_B;
			end
			S_ACC_B: begin
				cmd.op  = OP_ACC_B;
				state_d = S_ACC_H;
			end
			S_ACC_H: begin
				cmd.op  = OP_ACC_H;
				state_d = S_LIMIT;
			end
			S_LIMIT: begin
				cmd.op  = OP_LIMIT;
				state_d = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.op  = OP_CLAMP;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				// hold the result until the output register is free
				if (slot_free) begin
					cmd.op  = OP_WRITE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && action == ACT_START) running_q <= 1'b1;
			else if (accept && action == ACT_STOP) running_q <= 1'b0;
			if (cmd.op == OP_WRITE) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.div_busy)
		else $error("divider started while busy");

	a_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_WRITE) |-> slot_free)
		else $error("result written over a pending one");

	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_WRITE) |=> out_valid_q)
		else $error("written result not presented");

	a_capture_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CAP_I || cmd.op == OP_CAP_D || cmd.op == OP_CAP_L)
		|-> status.div_done)
		else $error("quotient captured before divider finished");

endmodule

@@ rtl/core/slew_limited_pid_drive_unit.sv @@
// ----------------------------------------------------------------------------
// slew_limited_pid_drive_unit
// Slew-limited PID drive for one 16-bit DAC value.
// ----------------------------------------------------------------------------
// A start request clears the integral and previous error and loads the held
// output; a stop request halts the loop. A sample request while running with
// nonzero elapsed_ms yields one drive value, computed by the 64-step serial
// division of the derivative by elapsed_ms, the two divisions by 1000
// (integral and slew bound) as four-step reciprocal multiplies, and steps of
// the shared 33x33 multiplier and the accumulator for the rest. The block
// takes one request at a time; a finished drive value waits in the output
// register while the next request is accepted, and a new one is held back,
// stalling the block, for as long as the previous one is not taken.
module slew_limited_pid_drive_unit
	import sld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // measured, elapsed_ms, start_output
	input  logic [1:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // drive
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	sld_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.action     (s_axis_tuser),
		.elapsed_ms (s_axis_tdata[31:16]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.status     (status),
		.cmd        (cmd)
	);

	sld_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.measured     (s_axis_tdata[15:0]),
		.elapsed_ms   (s_axis_tdata[31:16]),
		.start_output (s_axis_tdata[47:32]),
		.cmd          (cmd),
		.status       (status),
		.drive        (m_axis_tdata)
	);

endmodule
